// ===== src/hrlp_pkg.sv =====
// ----------------------------------------------------------------------------
// HTTP request line parser package
// Shared types, widths, register indexes and character codes.
// ----------------------------------------------------------------------------
package hrlp_pkg;

    localparam int BYTE_W      = 8;
    localparam int STATE_W     = 5;
    localparam int KIND_W      = 2;
    localparam int DIGIT_W     = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int WS_LIMIT_W  = 8;
    localparam int MTH_LIMIT_W = 8;
    localparam int URI_LIMIT_W = 12;
    localparam int SPACE_CNT_W = 9;
    localparam int MTH_CNT_W   = 9;
    localparam int URI_CNT_W   = 13;

    typedef enum logic [STATE_W-1:0] {
        ST_METHOD     = 5'd0,
        ST_URI        = 5'd1,
        ST_H          = 5'd2,
        ST_T1         = 5'd3,
        ST_T2         = 5'd4,
        ST_P          = 5'd5,
        ST_SLASH      = 5'd6,
        ST_MAJOR      = 5'd7,
        ST_DOT        = 5'd8,
        ST_MINOR      = 5'd9,
        ST_CR         = 5'd10,
        ST_LF         = 5'd11,
        ST_VALID      = 5'd12,
        ST_ERR_METHOD = 5'd13,
        ST_ERR_WS     = 5'd14,
        ST_ERR_URI    = 5'd15,
        ST_ERR_CRLF   = 5'd16
    } parse_state_t;

    typedef enum logic [KIND_W-1:0] {
        TOK_NONE   = 2'd0,
        TOK_METHOD = 2'd1,
        TOK_URI    = 2'd2
    } token_kind_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STRICT_CRLF   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WS        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_METHOD    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_URI       = 2'd3;

    localparam logic [WS_LIMIT_W-1:0]  MAX_WS_RST     = 8'd8;
    localparam logic [MTH_LIMIT_W-1:0] MAX_METHOD_RST = 8'd16;
    localparam logic [URI_LIMIT_W-1:0] MAX_URI_RST    = 12'd1024;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_H     = 8'h48;
    localparam logic [BYTE_W-1:0] CH_T     = 8'h54;
    localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
    localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
    localparam logic [BYTE_W-1:0] CH_Z     = 8'h5A;

endpackage

// ===== src/hrlp_if.sv =====
// ----------------------------------------------------------------------------
// HTTP request line parser channels
// Byte input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface hrlp_byte_if;
    logic                          valid;
    logic                          ready;
    logic [hrlp_pkg::BYTE_W-1:0]   in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface hrlp_result_if;
    logic                          valid;
    logic                          ready;
    logic                          accepted;
    logic [hrlp_pkg::STATE_W-1:0]  line_state;
    logic [hrlp_pkg::KIND_W-1:0]   token_kind;
    logic [hrlp_pkg::BYTE_W-1:0]   token_byte;
    logic [hrlp_pkg::DIGIT_W-1:0]  major_digit;
    logic [hrlp_pkg::DIGIT_W-1:0]  minor_digit;

    modport source (output valid, output accepted, output line_state, output token_kind,
                    output token_byte, output major_digit, output minor_digit,
                    input ready);
    modport sink   (input valid, input accepted, input line_state, input token_kind,
                    input token_byte, input major_digit, input minor_digit,
                    output ready);
endinterface

interface hrlp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [hrlp_pkg::CFG_IDX_W-1:0]  index;
    logic [hrlp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/http_request_line_parser_core.sv =====
// ----------------------------------------------------------------------------
// HTTP request line parser core
// Path: an accepted byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken.
// Reset (rst_n low, asynchronous): parser back to the method state, counters
// and version digits cleared, strict CRLF off, limit registers to 8, 16 and 1024.
// ----------------------------------------------------------------------------
module http_request_line_parser_core (
    input  logic          clk,
    input  logic          rst_n,
    hrlp_byte_if.sink     byte_ch,
    hrlp_result_if.source result_ch,
    hrlp_cfg_if.sink      cfg
);
    import hrlp_pkg::*;

    // Configuration
    logic                   strict_crlf_reg;
    logic [WS_LIMIT_W-1:0]  max_ws_reg;
    logic [MTH_LIMIT_W-1:0] max_method_reg;
    logic [URI_LIMIT_W-1:0] max_uri_reg;

    // Input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // Parser state
    parse_state_t           state_reg, state_next;
    logic [SPACE_CNT_W-1:0] space_reg, space_next;
    logic [MTH_CNT_W-1:0]   method_reg, method_next;
    logic [URI_CNT_W-1:0]   uri_reg, uri_next;
    logic [DIGIT_W-1:0]     major_reg, major_next;
    logic [DIGIT_W-1:0]     minor_reg, minor_next;

    // Result register
    logic               out_valid_reg;
    logic               accepted_reg;
    token_kind_t        kind_reg;
    logic [BYTE_W-1:0]  token_byte_reg;

    logic        ok;
    token_kind_t kind;
    logic        advance;

    logic                   is_upper, is_blank, is_digit, is_eol;
    logic [SPACE_CNT_W-1:0] space_inc;
    logic [MTH_CNT_W-1:0]   method_inc;
    logic [URI_CNT_W-1:0]   uri_inc;
    logic                   ws_over, method_over, uri_over;

    assign advance = in_valid_reg && (!out_valid_reg || result_ch.ready);

    assign byte_ch.ready = !in_valid_reg || advance;
    assign cfg.ready     = 1'b1;

    assign is_upper = (in_byte_reg >= CH_A) && (in_byte_reg <= CH_Z);
    assign is_blank = (in_byte_reg == CH_SP) || (in_byte_reg == CH_TAB);
    assign is_digit = (in_byte_reg >= CH_0) && (in_byte_reg <= CH_9);
    assign is_eol   = (in_byte_reg == CH_CR) || (in_byte_reg == CH_LF);

    // Saturating increments
    assign space_inc  = (&space_reg)  ? space_reg  : space_reg  + 1'b1;
    assign method_inc = (&method_reg) ? method_reg : method_reg + 1'b1;
    assign uri_inc    = (&uri_reg)    ? uri_reg    : uri_reg    + 1'b1;

    assign ws_over     = space_inc  > {1'b0, max_ws_reg};
    assign method_over = method_inc > {1'b0, max_method_reg};
    assign uri_over    = uri_inc    > {1'b0, max_uri_reg};

    // Next state and counters
    always_comb
    begin
        state_next  = state_reg;
        space_next  = space_reg;
        method_next = method_reg;
        uri_next    = uri_reg;
        major_next  = major_reg;
        minor_next  = minor_reg;
        unique case (state_reg)
            ST_METHOD:
            begin
                if (is_upper)
                begin
                    method_next = method_inc;
                    if (method_over)
                        state_next = ST_ERR_METHOD;
                end
                else if (is_blank && (method_reg != '0))
                begin
                    space_next = SPACE_CNT_W'(1);
                    state_next = ST_URI;
                end
            end
            ST_URI:
            begin
                if (is_eol)
                begin
                    // reject, hold state
                end
                else if (is_blank)
                begin
                    space_next = space_inc;
                    if (ws_over)
                        state_next = ST_ERR_WS;
                    else if (uri_reg != '0)
                    begin
                        space_next = SPACE_CNT_W'(1);
                        state_next = ST_H;
                    end
                end
                else
                begin
                    uri_next = uri_inc;
                    if (uri_over)
                        state_next = ST_ERR_URI;
                end
            end
            ST_H:
            begin
                if (is_blank)
                begin
                    space_next = space_inc;
                    if (ws_over)
                        state_next = ST_ERR_WS;
                end
                else if (in_byte_reg == CH_H)
                    state_next = ST_T1;
            end
            ST_T1:    if (in_byte_reg == CH_T)     state_next = ST_T2;
            ST_T2:    if (in_byte_reg == CH_T)     state_next = ST_P;
            ST_P:     if (in_byte_reg == CH_P)     state_next = ST_SLASH;
            ST_SLASH: if (in_byte_reg == CH_SLASH) state_next = ST_MAJOR;
            ST_MAJOR:
            begin
                if (is_digit)
                begin
                    major_next = in_byte_reg[DIGIT_W-1:0];
                    state_next = ST_DOT;
                end
            end
            ST_DOT:   if (in_byte_reg == CH_DOT)   state_next = ST_MINOR;
            ST_MINOR:
            begin
                if (is_digit)
                begin
                    minor_next = in_byte_reg[DIGIT_W-1:0];
                    state_next = ST_CR;
                end
            end
            ST_CR:
            begin
                if (in_byte_reg == CH_CR)
                    state_next = ST_LF;
                else if (!strict_crlf_reg && (in_byte_reg == CH_LF))
                    state_next = ST_VALID;
                else
                    state_next = ST_ERR_CRLF;
            end
            ST_LF:    if (in_byte_reg == CH_LF)    state_next = ST_VALID;
            default:
            begin
                // final states hold
            end
        endcase
    end

    // Accept flag and token tag
    always_comb
    begin
        ok   = 1'b0;
        kind = TOK_NONE;
        unique case (state_reg)
            ST_METHOD:
            begin
                if (is_upper)
                begin
                    kind = TOK_METHOD;
                    ok   = !method_over;
                end
                else
                    ok = is_blank && (method_reg != '0);
            end
            ST_URI:
            begin
                if (is_eol)
                    ok = 1'b0;
                else if (is_blank)
                    ok = !ws_over;
                else
                begin
                    kind = TOK_URI;
                    ok   = !uri_over;
                end
            end
            ST_H:     ok = is_blank ? !ws_over : (in_byte_reg == CH_H);
            ST_T1:    ok = (in_byte_reg == CH_T);
            ST_T2:    ok = (in_byte_reg == CH_T);
            ST_P:     ok = (in_byte_reg == CH_P);
            ST_SLASH: ok = (in_byte_reg == CH_SLASH);
            ST_MAJOR: ok = is_digit;
            ST_DOT:   ok = (in_byte_reg == CH_DOT);
            ST_MINOR: ok = is_digit;
            ST_CR:    ok = (in_byte_reg == CH_CR) ||
                           (!strict_crlf_reg && (in_byte_reg == CH_LF));
            ST_LF:    ok = (in_byte_reg == CH_LF);
            default:  ok = 1'b0;
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strict_crlf_reg <= 1'b0;
            max_ws_reg      <= MAX_WS_RST;
            max_method_reg  <= MAX_METHOD_RST;
            max_uri_reg     <= MAX_URI_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_STRICT_CRLF: strict_crlf_reg <= cfg.data[0];
                CFG_MAX_WS:      max_ws_reg      <= cfg.data[WS_LIMIT_W-1:0];
                CFG_MAX_METHOD:  max_method_reg  <= cfg.data[MTH_LIMIT_W-1:0];
                CFG_MAX_URI:     max_uri_reg     <= cfg.data[URI_LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (byte_ch.ready)
            in_valid_reg <= byte_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_ch.valid && byte_ch.ready)
            in_byte_reg <= byte_ch.in_byte;
    end

    // Parser state, advance one byte at a time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_METHOD;
            space_reg  <= '0;
            method_reg <= '0;
            uri_reg    <= '0;
            major_reg  <= '0;
            minor_reg  <= '0;
        end
        else if (advance)
        begin
            state_reg  <= state_next;
            space_reg  <= space_next;
            method_reg <= method_next;
            uri_reg    <= uri_next;
            major_reg  <= major_next;
            minor_reg  <= minor_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (result_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            accepted_reg   <= ok;
            kind_reg       <= kind;
            token_byte_reg <= (kind != TOK_NONE) ? in_byte_reg : '0;
        end
    end

    // Digits and state are shown from the live registers, which change only on advance
    assign result_ch.valid       = out_valid_reg;
    assign result_ch.accepted    = accepted_reg;
    assign result_ch.line_state  = state_reg;
    assign result_ch.token_kind  = kind_reg;
    assign result_ch.token_byte  = token_byte_reg;
    assign result_ch.major_digit = major_reg;
    assign result_ch.minor_digit = minor_reg;

endmodule
